// File: rtl/core/srlp_pkg.sv
// Shared types, widths and codes for the serpentine raster laser path block.
package srlp_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int COL_W = $clog2(MAX_DIMENSION);
  localparam int ROW_W = COL_W + 1;
  localparam int PIX_W = ROW_W + 1;

  localparam int CMD_W = 2;
  localparam int RGB_W = 24;
  localparam int KIND_W = 4;
  localparam int POS_W = 48;
  localparam int POWER_W = 16;

  localparam int MODE_W = 2;
  localparam int STEP_W = 32;
  localparam int WIDTH_W = 13;
  localparam int BOX_W = 12;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W = 32;
  localparam int PROD_W = PIX_W + STEP_W;

  localparam int MAX_OPS = 4;
  localparam int OP_IDX_W = $clog2(MAX_OPS);
  localparam int CNT_W = $clog2(MAX_OPS + 1);

  localparam int REC_DEPTH = 4;
  localparam int REC_PTR_W = $clog2(REC_DEPTH);
  localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [RGB_W-1:0] BLANK_RGB = '1;

  localparam logic [MODE_W-1:0] RST_POWER_MODE = MODE_W'(1);
  localparam logic [POWER_W-1:0] RST_LASER_POWER = '0;
  localparam logic [POWER_W-1:0] RST_FEED_RATE = '0;
  localparam logic [STEP_W-1:0] RST_STEP_LENGTH = STEP_W'(65536);
  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = WIDTH_W'(4096);
  localparam logic [BOX_W-1:0] RST_FIRST_COLUMN = '0;
  localparam logic [BOX_W-1:0] RST_LAST_COLUMN = BOX_W'(4095);
  localparam logic [BOX_W-1:0] RST_FIRST_ROW = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_ROW_END   = 2'd1,
    CMD_JOB_START = 2'd2,
    CMD_JOB_END   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ABS_MODE = 4'd0,
    KIND_FEED     = 4'd1,
    KIND_HOME     = 4'd2,
    KIND_CONST_ON = 4'd3,
    KIND_DYN_ON   = 4'd4,
    KIND_RAPID_X  = 4'd5,
    KIND_CUT_X    = 4'd6,
    KIND_RAPID_Y  = 4'd7,
    KIND_LASER_OFF = 4'd8,
    KIND_HOME_OFF = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_OFF  = 2'd1,
    RUN_ON   = 2'd2
  } run_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 2'd0,
    MODE_CONSTANT = 2'd1,
    MODE_DYNAMIC  = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POWER_MODE   = 3'd0,
    REG_LASER_POWER  = 3'd1,
    REG_FEED_RATE    = 3'd2,
    REG_STEP_LENGTH  = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_FIRST_COLUMN = 3'd5,
    REG_LAST_COLUMN  = 3'd6,
    REG_FIRST_ROW    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]  power_mode;
    logic [POWER_W-1:0] laser_power;
    logic [POWER_W-1:0] feed_rate;
    logic [STEP_W-1:0]  step_length;
    logic [WIDTH_W-1:0] image_width;
    logic [BOX_W-1:0]   first_column;
    logic [BOX_W-1:0]   last_column;
    logic [BOX_W-1:0]   first_row;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [PIX_W-1:0]   pix;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    op_t [MAX_OPS-1:0]           ops;
  } rec_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   position;
    logic [POWER_W-1:0] power;
    logic               last;
  } res_t;

endpackage

// File: rtl/core/srlp_front.sv
// Front end: accepts words, tracks run, column and row, and builds move records.
module srlp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  srlp_pkg::cfg_t              cfg,
  input  logic                        push,
  output logic                        full,
  input  logic [srlp_pkg::CMD_W-1:0]  command,
  input  logic [srlp_pkg::RGB_W-1:0]  pixel_rgb,
  input  logic                        rec_full,
  output logic                        rec_push,
  output srlp_pkg::rec_t              rec
);
  import srlp_pkg::*;

  run_t             run;
  run_t             run_next;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             start_row;
  logic             accept;
  logic             odd;
  logic             blank;
  logic [PIX_W-1:0] prev;
  logic [PIX_W-1:0] edge_col;
  logic [PIX_W-1:0] row_up;

  assign full = rec_full;
  assign accept = push && !rec_full;
  assign rec_push = accept && (rec.count != '0);

  assign odd = row[0];
  assign blank = (pixel_rgb == BLANK_RGB);
  assign row_up = PIX_W'(row) + PIX_W'(1);

  always_comb begin
    if (odd) begin
      prev = PIX_W'(col) + PIX_W'(1);
      edge_col = '0;
    end else begin
      prev = (col != '0) ? PIX_W'(col - COL_W'(1)) : '0;
      edge_col = (cfg.image_width != '0) ? PIX_W'(cfg.image_width - WIDTH_W'(1)) : '0;
    end
  end

  always_comb begin
    rec = '0;
    run_next = run;
    col_next = col;
    row_next = row;
    start_row = 1'b0;
    unique case (cmd_t'(command))
      CMD_PIXEL: begin
        if (blank && (run == RUN_ON)) begin
          rec.count = CNT_W'(1);
          rec.ops[0] = '{kind: KIND_CUT_X, pix: prev};
        end else if (!blank && (run == RUN_OFF)) begin
          rec.count = CNT_W'(1);
          rec.ops[0] = '{kind: KIND_RAPID_X, pix: prev};
        end
        run_next = blank ? RUN_OFF : RUN_ON;
        if (odd) begin
          if (col != '0) col_next = col - COL_W'(1);
        end else begin
          if (col < COL_W'(MAX_DIMENSION - 1)) col_next = col + COL_W'(1);
        end
      end
      CMD_ROW_END: begin
        if (run == RUN_NONE) begin
          rec.count = CNT_W'(1);
          rec.ops[0] = '{kind: KIND_RAPID_Y, pix: row_up};
        end else begin
          rec.count = CNT_W'(2);
          rec.ops[0] = '{kind: (run == RUN_ON) ? KIND_CUT_X : KIND_RAPID_X, pix: edge_col};
          rec.ops[1] = '{kind: KIND_RAPID_Y, pix: row_up};
        end
        if (row < ROW_W'(2 * MAX_DIMENSION - 1)) row_next = row + ROW_W'(1);
        start_row = 1'b1;
      end
      CMD_JOB_START: begin
        rec.ops[0] = '{kind: KIND_ABS_MODE, pix: '0};
        rec.ops[1] = '{kind: KIND_FEED, pix: '0};
        rec.ops[2] = '{kind: KIND_HOME, pix: '0};
        unique case (mode_t'(cfg.power_mode))
          MODE_CONSTANT: begin
            rec.count = CNT_W'(4);
            rec.ops[3] = '{kind: KIND_CONST_ON, pix: '0};
          end
          MODE_DYNAMIC: begin
            rec.count = CNT_W'(4);
            rec.ops[3] = '{kind: KIND_DYN_ON, pix: '0};
          end
          default: rec.count = CNT_W'(3);
        endcase
        row_next = ROW_W'(cfg.first_row);
        start_row = 1'b1;
      end
      CMD_JOB_END: begin
        rec.count = CNT_W'(2);
        rec.ops[0] = '{kind: KIND_LASER_OFF, pix: '0};
        rec.ops[1] = '{kind: KIND_HOME_OFF, pix: '0};
        row_next = ROW_W'(cfg.first_row);
        start_row = 1'b1;
      end
    endcase
    if (start_row) begin
      run_next = RUN_NONE;
      col_next = row_next[0] ? COL_W'(cfg.last_column) : COL_W'(cfg.first_column);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= RUN_NONE;
      row <= ROW_W'(RST_FIRST_ROW);
      col <= RST_FIRST_ROW[0] ? COL_W'(RST_LAST_COLUMN) : COL_W'(RST_FIRST_COLUMN);
    end else if (accept) begin
      run <= run_next;
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

// File: rtl/core/srlp_queue.sv
// Record queue between the front end and the move sequencer.
module srlp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  srlp_pkg::rec_t wr_data,
  output logic           full,
  input  logic           rd,
  output srlp_pkg::rec_t rd_data,
  output logic           empty
);
  import srlp_pkg::*;

  rec_t                 store [REC_DEPTH];
  logic [REC_PTR_W-1:0] wptr;
  logic [REC_PTR_W-1:0] rptr;
  logic [REC_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full = (count == REC_CNT_W'(REC_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = store[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + REC_PTR_W'(1);
      if (do_rd) rptr <= rptr + REC_PTR_W'(1);
      if (do_wr && !do_rd) count <= count + REC_CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - REC_CNT_W'(1);
    end
  end

endmodule

// File: rtl/core/srlp_back.sv
// Back end: steps through record moves, scales positions and buffers results.
module srlp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  srlp_pkg::cfg_t                cfg,
  input  srlp_pkg::rec_t                rec,
  input  logic                          rec_empty,
  output logic                          rec_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [srlp_pkg::KIND_W-1:0]   kind,
  output logic [srlp_pkg::POS_W-1:0]    position,
  output logic [srlp_pkg::POWER_W-1:0]  power,
  output logic                          last
);
  import srlp_pkg::*;

  logic [OP_IDX_W-1:0]  idx;
  op_t                  cur_op;
  logic                 is_last;
  logic                 room;
  logic                 issue;

  logic                 iss_valid;
  kind_t                iss_kind;
  logic [PIX_W-1:0]     iss_pix;
  logic                 iss_last;

  logic [PROD_W-1:0]    product;
  res_t                 res;

  res_t                 obuf [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wptr;
  logic [OUT_PTR_W-1:0] rptr;
  logic [OUT_CNT_W-1:0] count;
  logic                 do_rd;

  assign cur_op = rec.ops[idx];
  assign is_last = ((CNT_W'(idx) + CNT_W'(1)) >= rec.count);
  assign room = ((OUT_CNT_W + 1)'(count) + (OUT_CNT_W + 1)'(iss_valid))
                < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign issue = !rec_empty && room;
  assign rec_pop = issue && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      iss_valid <= 1'b0;
    end else begin
      iss_valid <= issue;
      if (issue) begin
        idx <= is_last ? '0 : idx + OP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      iss_kind <= cur_op.kind;
      iss_pix <= cur_op.pix;
      iss_last <= is_last;
    end
  end

  assign product = PROD_W'(iss_pix) * PROD_W'(cfg.step_length);

  always_comb begin
    res.kind = iss_kind;
    res.position = POS_W'(product);
    res.last = iss_last;
    priority if (iss_kind == KIND_CUT_X) begin
      res.power = cfg.laser_power;
    end else if (iss_kind == KIND_FEED) begin
      res.power = cfg.feed_rate;
    end else begin
      res.power = '0;
    end
  end

  assign empty = (count == '0);
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (iss_valid) begin
      obuf[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (iss_valid) wptr <= wptr + OUT_PTR_W'(1);
      if (do_rd) rptr <= rptr + OUT_PTR_W'(1);
      if (iss_valid && !do_rd) count <= count + OUT_CNT_W'(1);
      else if (do_rd && !iss_valid) count <= count - OUT_CNT_W'(1);
    end
  end

  assign kind = obuf[rptr].kind;
  assign position = obuf[rptr].position;
  assign power = obuf[rptr].power;
  assign last = obuf[rptr].last;

endmodule

// File: rtl/core/serpentine_raster_laser_path_top.sv
// Top level of the serpentine raster laser path generator.
//
//   channel   direction  handshake             words
//   input     in         push / full           command, pixel_rgb
//   result    out        empty / pop           kind, position, power, last
//   config    in         write_enable          reg_index, write_data
//
// One input word is taken per cycle while the record queue has room; a pixel
// word yields at most one move, so pixels stream at one per cycle.
// Row-end, job-start and job-end words yield one to four moves, which the move
// sequencer issues one per cycle while the result buffer has room; a result
// passes the record queue, issue register and result buffer to the ports.
// Reset is synchronous and empties both queues and restores the job start state.
// A stalled result side fills the result buffer, then the record queue, then
// raises full.
module serpentine_raster_laser_path_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [srlp_pkg::CMD_W-1:0]     command,
  input  logic [srlp_pkg::RGB_W-1:0]     pixel_rgb,
  output logic                           empty,
  input  logic                           pop,
  output logic [srlp_pkg::KIND_W-1:0]    kind,
  output logic [srlp_pkg::POS_W-1:0]     position,
  output logic [srlp_pkg::POWER_W-1:0]   power,
  output logic                           last,
  input  logic                           write_enable,
  input  logic [srlp_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [srlp_pkg::DATA_W-1:0]    write_data
);
  import srlp_pkg::*;

  cfg_t cfg;
  rec_t rec_in;
  rec_t rec_out;
  logic rec_push;
  logic rec_full;
  logic rec_pop;
  logic rec_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_mode <= RST_POWER_MODE;
      cfg.laser_power <= RST_LASER_POWER;
      cfg.feed_rate <= RST_FEED_RATE;
      cfg.step_length <= RST_STEP_LENGTH;
      cfg.image_width <= RST_IMAGE_WIDTH;
      cfg.first_column <= RST_FIRST_COLUMN;
      cfg.last_column <= RST_LAST_COLUMN;
      cfg.first_row <= RST_FIRST_ROW;
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_POWER_MODE:   cfg.power_mode <= write_data[MODE_W-1:0];
        REG_LASER_POWER:  cfg.laser_power <= write_data[POWER_W-1:0];
        REG_FEED_RATE:    cfg.feed_rate <= write_data[POWER_W-1:0];
        REG_STEP_LENGTH:  cfg.step_length <= write_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width <= write_data[WIDTH_W-1:0];
        REG_FIRST_COLUMN: cfg.first_column <= write_data[BOX_W-1:0];
        REG_LAST_COLUMN:  cfg.last_column <= write_data[BOX_W-1:0];
        REG_FIRST_ROW:    cfg.first_row <= write_data[BOX_W-1:0];
      endcase
    end
  end

  srlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .command   (command),
    .pixel_rgb (pixel_rgb),
    .rec_full  (rec_full),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  srlp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_push),
    .wr_data (rec_in),
    .full    (rec_full),
    .rd      (rec_pop),
    .rd_data (rec_out),
    .empty   (rec_empty)
  );

  srlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec       (rec_out),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .position  (position),
    .power     (power),
    .last      (last)
  );

  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> (rec_in.count != '0) && (rec_in.count <= CNT_W'(MAX_OPS)))
    else $error("record with bad move count");

  a_pixel_one: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (command == CMD_PIXEL)) |-> (rec_in.count <= CNT_W'(1)))
    else $error("pixel word produced more than one move");

  a_job_end_two: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (command == CMD_JOB_END)) |-> (rec_in.count == CNT_W'(2)))
    else $error("job end did not produce two moves");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
